// ===== sv/obbcsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package obbcsp_pkg;

    // Quaternion products and rotation entries
    localparam int R28_W = 35;
    localparam int R14_W = 21;
    // Homogeneous coordinates after saturation
    localparam int H_W = 42;
    localparam logic signed [63:0] HOMO_LIMIT = 64'sd2199023255551;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [63:0] ROW_ZERO_RESET  = 64'd4096;
    localparam logic [63:0] ROW_ONE_RESET   = 64'd268435456;
    localparam logic [63:0] ROW_TWO_RESET   = 64'd17592186044416;
    localparam logic [63:0] ROW_THREE_RESET = 64'd1152921504606846976;
    localparam logic [31:0] RES_RESET       = 32'd47187200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_ZERO   = 3'd0,
        REG_ROW_ONE    = 3'd1,
        REG_ROW_TWO    = 3'd2,
        REG_ROW_THREE  = 3'd3,
        REG_TARGET_RES = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0] idx;
        logic       last;
        logic       bad;
    } tag_t;

    // Bit i set: offset along axis i is +half extent
    function automatic logic [2:0] corner_signs(input logic [2:0] k);
        logic [2:0] s;
        case (k)
            3'd0:    s = 3'b010;
            3'd1:    s = 3'b011;
            3'd2:    s = 3'b000;
            3'd3:    s = 3'b001;
            3'd4:    s = 3'b111;
            3'd5:    s = 3'b110;
            3'd6:    s = 3'b101;
            default: s = 3'b100;
        endcase
        return s;
    endfunction

    // Matrix column feeding homogeneous lane X, Y, W
    function automatic int mat_col(input int lane);
        return (lane == 2) ? 3 : lane;
    endfunction

endpackage
`default_nettype wire

// ===== sv/obbcsp_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface obbcsp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [obbcsp_pkg::CFG_IDX_W-1:0]  index;
    logic [obbcsp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/obbcsp_box_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface obbcsp_box_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic signed [COORD_BITS-1:0] centre_z;
    logic [COORD_BITS-1:0]        extent_x;
    logic [COORD_BITS-1:0]        extent_y;
    logic [COORD_BITS-1:0]        extent_z;
    logic signed [15:0]           quat_x;
    logic signed [15:0]           quat_y;
    logic signed [15:0]           quat_z;
    logic signed [15:0]           quat_w;

    modport source (
        output valid, output centre_x, output centre_y, output centre_z,
        output extent_x, output extent_y, output extent_z,
        output quat_x, output quat_y, output quat_z, output quat_w,
        input ready
    );
    modport sink (
        input valid, input centre_x, input centre_y, input centre_z,
        input extent_x, input extent_y, input extent_z,
        input quat_x, input quat_y, input quat_z, input quat_w,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/obbcsp_corner_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface obbcsp_corner_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   corner_index;
    logic signed [COORD_BITS-1:0] screen_x;
    logic signed [COORD_BITS-1:0] screen_y;
    logic                         w_invalid;
    logic                         last_corner;

    modport source (
        output valid, output corner_index, output screen_x, output screen_y,
        output w_invalid, output last_corner, input ready
    );
    modport sink (
        input valid, input corner_index, input screen_x, input screen_y,
        input w_invalid, input last_corner, output ready
    );
endinterface
`default_nettype wire

// ===== sv/obbcsp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-lane pipelined restoring divider, shared divisor, one quotient bit per stage.
module obbcsp_div #(
    parameter int QB  = 16,
    parameter int A_W = 66,
    parameter int D_W = 43
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [1:0][A_W-1:0]         in_a,
    input  logic [1:0]                  in_neg,
    input  logic [D_W-1:0]              in_d,
    input  obbcsp_pkg::tag_t            in_tag,
    output logic                        out_valid,
    output logic [1:0][QB-1:0]          out_q,
    output logic [1:0]                  out_ovf,
    output logic [1:0]                  out_neg,
    output obbcsp_pkg::tag_t            out_tag
);

    localparam int DW = A_W + QB;

    logic             vld_reg [QB+1];
    logic [DW-1:0]    rem_reg [QB+1][2];
    logic [DW-1:0]    rem_next [QB+1][2];
    logic [QB-1:0]    q_reg [QB+1][2];
    logic [QB-1:0]    q_next [QB+1][2];
    logic [1:0]       ovf_reg [QB+1];
    logic [1:0]       ovf_next [QB+1];
    logic [1:0]       neg_reg [QB+1];
    logic [D_W-1:0]   d_reg [QB+1];
    obbcsp_pkg::tag_t tag_reg [QB+1];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            rem_next[0][l] = DW'(in_a[l]);
            q_next[0][l]   = '0;
            ovf_next[0][l] = DW'(in_a[l]) >= (DW'(in_d) << QB);
        end
        for (int s = 1; s <= QB; s++)
        begin
            ovf_next[s] = ovf_reg[s-1];
            for (int l = 0; l < 2; l++)
            begin
                rem_next[s][l] = rem_reg[s-1][l];
                q_next[s][l]   = q_reg[s-1][l];
                if (rem_reg[s-1][l] >= (DW'(d_reg[s-1]) << (QB - s)))
                begin
                    rem_next[s][l] = rem_reg[s-1][l] - (DW'(d_reg[s-1]) << (QB - s));
                    q_next[s][l][QB-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= QB; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                ovf_reg[s] <= ovf_next[s];
            end
            neg_reg[0] <= in_neg;
            d_reg[0]   <= in_d;
            tag_reg[0] <= in_tag;
            for (int s = 1; s <= QB; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid  = vld_reg[QB];
    assign out_q[0]   = q_reg[QB][0];
    assign out_q[1]   = q_reg[QB][1];
    assign out_ovf    = ovf_reg[QB];
    assign out_neg    = neg_reg[QB];
    assign out_tag    = tag_reg[QB];

endmodule
`default_nettype wire

// ===== sv/obb_corner_screen_projection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Oriented box corner projector.
// box:    one word per oriented box (centre, full extent, Q1.14 quaternion).
// corner: eight words per box, corners 0..7 in fixed order, last_corner on 7.
// cfg:    register writes (matrix rows 0..3, target resolution); always ready.
//         Write only while no box is in flight.
// Throughput: one corner word per cycle while corner.ready does not stall. The
// corner sequencer holds a box while it issues its eight corners; a second box
// waits in the input register, so box.ready drops while that register is full
// and cannot hand its box on (sequencer busy or output stalled). Each corner
// passes stages C1 to C8, the divider (one quotient bit per stage) and the
// output register.
// A stall on corner.ready freezes every stage in place; nothing is dropped.
// Reset (rst_n low, async) empties all stages and loads the identity matrix
// and a 1280 x 720 target.
module obb_corner_screen_projection #(
    parameter int COORD_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    obbcsp_cfg_if.sink      cfg,
    obbcsp_box_if.sink      box,
    obbcsp_corner_if.source corner
);

    localparam int CB     = COORD_BITS;
    localparam int R14_W  = obbcsp_pkg::R14_W;
    localparam int R28_W  = obbcsp_pkg::R28_W;
    localparam int H_W    = obbcsp_pkg::H_W;
    localparam int LOC_W  = CB + 1;
    localparam int RP_W   = R14_W + LOC_W;
    localparam int A1_W   = CB + 25;
    localparam int P_W    = CB + 14;
    localparam int MP_W   = P_W + 16;
    localparam int A2_W   = CB + 33;
    localparam int HR_W   = ((A2_W - 12 > H_W) ? A2_W - 12 : H_W) + 1;
    localparam int NUM_W  = H_W + 1;
    localparam int PR_W   = NUM_W + 17;
    localparam int N_W    = PR_W + 6;
    localparam int D_W    = H_W + 1;

    localparam logic [CB-1:0] S_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] S_MIN = {1'b1, {(CB-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [63:0] mat_reg [4];
    logic [31:0] res_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= obbcsp_pkg::ROW_ZERO_RESET;
            mat_reg[1] <= obbcsp_pkg::ROW_ONE_RESET;
            mat_reg[2] <= obbcsp_pkg::ROW_TWO_RESET;
            mat_reg[3] <= obbcsp_pkg::ROW_THREE_RESET;
            res_reg    <= obbcsp_pkg::RES_RESET;
        end
        else if (cfg.valid)
        begin
            case (obbcsp_pkg::cfg_reg_t'(cfg.index))
                obbcsp_pkg::REG_ROW_ZERO:   mat_reg[0] <= cfg.data;
                obbcsp_pkg::REG_ROW_ONE:    mat_reg[1] <= cfg.data;
                obbcsp_pkg::REG_ROW_TWO:    mat_reg[2] <= cfg.data;
                obbcsp_pkg::REG_ROW_THREE:  mat_reg[3] <= cfg.data;
                obbcsp_pkg::REG_TARGET_RES: res_reg    <= cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- stall control ----------------
    logic out_valid_reg;
    logic en;
    assign en = !out_valid_reg || corner.ready;

    // ---------------- stage A: box input register ----------------
    logic                 a_valid_reg;
    logic signed [CB-1:0] a_c [3];
    logic [CB-1:0]        a_e [3];
    logic signed [15:0]   a_qx, a_qy, a_qz, a_qw;

    // ---------------- stage B: corner sequencer ----------------
    logic                    b_valid_reg;
    logic [2:0]              b_cnt_reg;
    logic signed [CB-1:0]    b_c [3];
    logic [CB-1:0]           b_e [3];
    logic signed [R14_W-1:0] b_r14 [3][3];
    logic signed [R14_W-1:0] r14_next [3][3];

    logic box_take, a_to_b, issue, b_last;
    assign b_last   = b_cnt_reg == 3'd7;
    assign issue    = en && b_valid_reg;
    assign a_to_b   = a_valid_reg && en && (!b_valid_reg || b_last);
    assign box.ready = !a_valid_reg || a_to_b;
    assign box_take = box.valid && box.ready;

    // rotation matrix from the quaternion sandwich product, Q.28 -> Q.14
    logic signed [31:0]      pww, pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
    logic signed [R28_W-1:0] r28 [3][3];

    always_comb
    begin
        pww = a_qw * a_qw;
        pxx = a_qx * a_qx;
        pyy = a_qy * a_qy;
        pzz = a_qz * a_qz;
        pxy = a_qx * a_qy;
        pxz = a_qx * a_qz;
        pyz = a_qy * a_qz;
        pwx = a_qw * a_qx;
        pwy = a_qw * a_qy;
        pwz = a_qw * a_qz;
        r28[0][0] = R28_W'(pww) + R28_W'(pxx) - R28_W'(pyy) - R28_W'(pzz);
        r28[0][1] = (R28_W'(pxy) - R28_W'(pwz)) <<< 1;
        r28[0][2] = (R28_W'(pxz) + R28_W'(pwy)) <<< 1;
        r28[1][0] = (R28_W'(pxy) + R28_W'(pwz)) <<< 1;
        r28[1][1] = R28_W'(pww) - R28_W'(pxx) + R28_W'(pyy) - R28_W'(pzz);
        r28[1][2] = (R28_W'(pyz) - R28_W'(pwx)) <<< 1;
        r28[2][0] = (R28_W'(pxz) - R28_W'(pwy)) <<< 1;
        r28[2][1] = (R28_W'(pyz) + R28_W'(pwx)) <<< 1;
        r28[2][2] = R28_W'(pww) - R28_W'(pxx) - R28_W'(pyy) + R28_W'(pzz);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r14_next[i][j] = R14_W'((r28[i][j] + R28_W'(8192)) >>> 14);
            end
        end
    end

    // ---------------- corner pipeline payload ----------------
    logic                    c1_valid_reg, c2_valid_reg, c3_valid_reg, c4_valid_reg;
    logic                    c5_valid_reg, c6_valid_reg, c7_valid_reg, c8_valid_reg;
    logic [2:0]              c1_idx, c2_idx, c3_idx, c4_idx, c5_idx, c6_idx, c7_idx;
    logic [2:0]              c8_idx;
    logic signed [CB-1:0]    c1_c [3];
    logic signed [RP_W-1:0]  c1_rp [3][3];
    logic signed [P_W-1:0]   c2_p [3];
    logic signed [MP_W-1:0]  c3_mp [3][3];
    logic signed [15:0]      c3_m3 [3];
    logic signed [H_W-1:0]   c4_h [3];
    logic signed [NUM_W-1:0] c5_num [2];
    logic signed [H_W-1:0]   c5_w;
    logic                    c5_bad, c6_bad, c7_bad, c8_bad;
    logic signed [PR_W-1:0]  c6_prod [2];
    logic signed [H_W-1:0]   c6_w;
    logic signed [N_W-1:0]   c7_n [2];
    logic [D_W-1:0]          c7_d, c8_d;
    logic [1:0][N_W-1:0]     c8_a;
    logic [1:0]              c8_neg;

    // combinational next values
    logic [2:0]              sgn;
    logic signed [LOC_W-1:0] loc [3];
    logic signed [RP_W-1:0]  rp_next [3][3];
    logic signed [A1_W-1:0]  acc1 [3];
    logic signed [P_W-1:0]   p_next [3];
    logic signed [MP_W-1:0]  mp_next [3][3];
    logic signed [15:0]      m3_next [3];
    logic signed [A2_W-1:0]  acc2 [3];
    logic signed [HR_W-1:0]  hr [3];
    logic signed [H_W-1:0]   h_next [3];
    logic signed [PR_W-1:0]  prod_next [2];
    logic signed [N_W-1:0]   n_next [2];
    logic [1:0][N_W-1:0]     a_next;

    always_comb
    begin
        // C1: half-extent offsets times rotation (extent is Q.8, offset Q.9)
        sgn = obbcsp_pkg::corner_signs(b_cnt_reg);
        for (int j = 0; j < 3; j++)
        begin
            loc[j] = $signed({1'b0, b_e[j]});
            if (!sgn[j])
            begin
                loc[j] = -loc[j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rp_next[i][j] = b_r14[i][j] * loc[j];
            end
        end
        // C2: add centre, round to Q.12
        for (int i = 0; i < 3; i++)
        begin
            acc1[i] = (A1_W'(c1_c[i]) <<< 15) + A1_W'(c1_rp[i][0])
                      + A1_W'(c1_rp[i][1]) + A1_W'(c1_rp[i][2]);
            p_next[i] = P_W'((acc1[i] + A1_W'(1024)) >>> 11);
        end
        // C3: matrix products for X, Y and W
        for (int l = 0; l < 3; l++)
        begin
            m3_next[l] = $signed(mat_reg[3][16*obbcsp_pkg::mat_col(l) +: 16]);
            for (int i = 0; i < 3; i++)
            begin
                mp_next[i][l] = c2_p[i] *
                                $signed(mat_reg[i][16*obbcsp_pkg::mat_col(l) +: 16]);
            end
        end
        // C4: add translation, round, saturate
        for (int l = 0; l < 3; l++)
        begin
            acc2[l] = (A2_W'(c3_m3[l]) <<< 12) + A2_W'(c3_mp[0][l])
                      + A2_W'(c3_mp[1][l]) + A2_W'(c3_mp[2][l]);
            hr[l] = HR_W'((acc2[l] + A2_W'(2048)) >>> 12);
            if (hr[l] > HR_W'(obbcsp_pkg::HOMO_LIMIT))
            begin
                h_next[l] = H_W'(obbcsp_pkg::HOMO_LIMIT);
            end
            else if (hr[l] < -HR_W'(obbcsp_pkg::HOMO_LIMIT))
            begin
                h_next[l] = -H_W'(obbcsp_pkg::HOMO_LIMIT);
            end
            else
            begin
                h_next[l] = H_W'(hr[l]);
            end
        end
        // C6: scale by width / height
        prod_next[0] = c5_num[0] * $signed({1'b0, res_reg[15:0]});
        prod_next[1] = c5_num[1] * $signed({1'b0, res_reg[31:16]});
        // C7: numerator 16*num*size + w (Q.4 pixels, half-up via +w over 2w)
        for (int l = 0; l < 2; l++)
        begin
            n_next[l] = (N_W'(c6_prod[l]) <<< 4) + N_W'(c6_w);
        end
        // C8: floor division as unsigned magnitude division
        for (int l = 0; l < 2; l++)
        begin
            if (c7_n[l][N_W-1])
            begin
                a_next[l] = $unsigned(-c7_n[l]) + N_W'(c7_d) - N_W'(1);
            end
            else
            begin
                a_next[l] = $unsigned(c7_n[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            b_cnt_reg    <= 3'd0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            c4_valid_reg <= 1'b0;
            c5_valid_reg <= 1'b0;
            c6_valid_reg <= 1'b0;
            c7_valid_reg <= 1'b0;
            c8_valid_reg <= 1'b0;
        end
        else
        begin
            if (box_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_to_b)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_to_b)
            begin
                b_valid_reg <= 1'b1;
                b_cnt_reg   <= 3'd0;
            end
            else if (issue)
            begin
                if (b_last)
                begin
                    b_valid_reg <= 1'b0;
                end
                b_cnt_reg <= b_cnt_reg + 3'd1;
            end
            if (en)
            begin
                c1_valid_reg <= issue;
                c2_valid_reg <= c1_valid_reg;
                c3_valid_reg <= c2_valid_reg;
                c4_valid_reg <= c3_valid_reg;
                c5_valid_reg <= c4_valid_reg;
                c6_valid_reg <= c5_valid_reg;
                c7_valid_reg <= c6_valid_reg;
                c8_valid_reg <= c7_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_take)
        begin
            a_c[0] <= box.centre_x;
            a_c[1] <= box.centre_y;
            a_c[2] <= box.centre_z;
            a_e[0] <= box.extent_x;
            a_e[1] <= box.extent_y;
            a_e[2] <= box.extent_z;
            a_qx   <= box.quat_x;
            a_qy   <= box.quat_y;
            a_qz   <= box.quat_z;
            a_qw   <= box.quat_w;
        end
        if (a_to_b)
        begin
            b_c   <= a_c;
            b_e   <= a_e;
            b_r14 <= r14_next;
        end
        if (en)
        begin
            c1_idx  <= b_cnt_reg;
            c1_c    <= b_c;
            c1_rp   <= rp_next;
            c2_idx  <= c1_idx;
            c2_p    <= p_next;
            c3_idx  <= c2_idx;
            c3_mp   <= mp_next;
            c3_m3   <= m3_next;
            c4_idx  <= c3_idx;
            c4_h    <= h_next;
            c5_idx  <= c4_idx;
            c5_num[0] <= NUM_W'(c4_h[0]) + NUM_W'(c4_h[2]);
            c5_num[1] <= NUM_W'(c4_h[2]) - NUM_W'(c4_h[1]);
            c5_w    <= c4_h[2];
            c5_bad  <= c4_h[2][H_W-1] || (c4_h[2] == '0);
            c6_idx  <= c5_idx;
            c6_prod <= prod_next;
            c6_w    <= c5_w;
            c6_bad  <= c5_bad;
            c7_idx  <= c6_idx;
            c7_n    <= n_next;
            c7_d    <= {c6_w, 1'b0};
            c7_bad  <= c6_bad;
            c8_idx  <= c7_idx;
            c8_a    <= a_next;
            c8_neg  <= {c7_n[1][N_W-1], c7_n[0][N_W-1]};
            c8_d    <= c7_d;
            c8_bad  <= c7_bad;
        end
    end

    // ---------------- divider ----------------
    obbcsp_pkg::tag_t    c8_tag, div_tag;
    logic                div_valid;
    logic [1:0][CB-1:0]  div_q;
    logic [1:0]          div_ovf;
    logic [1:0]          div_neg;

    assign c8_tag.idx  = c8_idx;
    assign c8_tag.last = c8_idx == 3'd7;
    assign c8_tag.bad  = c8_bad;

    obbcsp_div #(
        .QB  (CB),
        .A_W (N_W),
        .D_W (D_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c8_valid_reg),
        .in_a      (c8_a),
        .in_neg    (c8_neg),
        .in_d      (c8_d),
        .in_tag    (c8_tag),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_ovf   (div_ovf),
        .out_neg   (div_neg),
        .out_tag   (div_tag)
    );

    // ---------------- sign, saturation and output register ----------------
    logic [CB-1:0] scr [2];
    logic [CB-1:0] sx_reg, sy_reg;
    logic [2:0]    idx_reg;
    logic          bad_reg, last_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (div_tag.bad)
            begin
                scr[l] = '0;
            end
            else if (!div_neg[l])
            begin
                scr[l] = (div_ovf[l] || div_q[l][CB-1]) ? S_MAX : div_q[l];
            end
            else
            begin
                scr[l] = (div_ovf[l] || (div_q[l] > S_MIN)) ? S_MIN : -div_q[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg   <= scr[0];
            sy_reg   <= scr[1];
            idx_reg  <= div_tag.idx;
            bad_reg  <= div_tag.bad;
            last_reg <= div_tag.last;
        end
    end

    assign corner.valid        = out_valid_reg;
    assign corner.corner_index = idx_reg;
    assign corner.screen_x     = $signed(sx_reg);
    assign corner.screen_y     = $signed(sy_reg);
    assign corner.w_invalid    = bad_reg;
    assign corner.last_corner  = last_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int CB = 16;
    localparam int LAT = CB + 11 + 8;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] cx, cy, cz, ex, ey, ez, qx, qy, qz, qw;
    } box_word_t;

    typedef struct packed {
        logic [2:0]  idx;
        logic [15:0] sx;
        logic [15:0] sy;
        logic        bad;
        logic        last;
    } corner_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    obbcsp_cfg_if cfg_bus ();
    obbcsp_box_if #(.COORD_BITS(CB)) box_bus ();
    obbcsp_corner_if #(.COORD_BITS(CB)) corner_bus ();

    obb_corner_screen_projection #(.COORD_BITS(CB)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .box    (box_bus.sink),
        .corner (corner_bus.source)
    );

    always #6 clk = ~clk;

    // Shadow copy of the configuration
    logic [63:0] mat_row [4];
    logic [31:0] target_res;

    box_word_t    box_queue [$];
    corner_word_t corner_expected [$];
    int  mismatches = 0;
    int  corners_seen = 0;
    int  boxes_sent = 0;
    int  idle_pct = 14;
    longint cycles = 0;

    // Pending register write, issued by the configuration process
    logic        cfg_req = 1'b0;
    logic [2:0]  cfg_req_idx;
    logic [63:0] cfg_req_data;
    logic        cfg_done = 1'b0;

    function automatic longint fdiv(longint a, longint b);
        if (a >= 0)
            return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return fdiv(v + (longint'(1) <<< (s - 1)), longint'(1) <<< s);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint to_pixels(longint num, longint w, longint size);
        longint r;
        r = fdiv(2 * num * (size * 8) + w, 2 * w);
        return clip(r, -32768, 32767);
    endfunction

    // Predict the eight corner words of one box and queue them
    task automatic predict_corners(input box_word_t b);
        longint q[4], c[3], e[3], m[4][4], r28[3][3], r14[3][3];
        longint loc[3], p[3], h[4], acc, sx, sy, wd, ht, hlim;
        logic [2:0] sg;
        corner_word_t cw;
        hlim = longint'(obbcsp_pkg::HOMO_LIMIT);
        q[0] = longint'($signed(b.qx));
        q[1] = longint'($signed(b.qy));
        q[2] = longint'($signed(b.qz));
        q[3] = longint'($signed(b.qw));
        c[0] = longint'($signed(b.cx));
        c[1] = longint'($signed(b.cy));
        c[2] = longint'($signed(b.cz));
        e[0] = longint'(b.ex);
        e[1] = longint'(b.ey);
        e[2] = longint'(b.ez);
        wd = longint'(target_res[15:0]);
        ht = longint'(target_res[31:16]);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                m[i][j] = longint'($signed(mat_row[i][16*j +: 16]));
        // Rotation from the sandwich product, x,y,z,w = q[0..3]
        r28[0][0] = q[3]*q[3] + q[0]*q[0] - q[1]*q[1] - q[2]*q[2];
        r28[0][1] = 2 * (q[0]*q[1] - q[3]*q[2]);
        r28[0][2] = 2 * (q[0]*q[2] + q[3]*q[1]);
        r28[1][0] = 2 * (q[0]*q[1] + q[3]*q[2]);
        r28[1][1] = q[3]*q[3] - q[0]*q[0] + q[1]*q[1] - q[2]*q[2];
        r28[1][2] = 2 * (q[1]*q[2] - q[3]*q[0]);
        r28[2][0] = 2 * (q[0]*q[2] - q[3]*q[1]);
        r28[2][1] = 2 * (q[1]*q[2] + q[3]*q[0]);
        r28[2][2] = q[3]*q[3] - q[0]*q[0] - q[1]*q[1] + q[2]*q[2];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r14[i][j] = rnd_shift(r28[i][j], 14);
        for (int k = 0; k < 8; k++)
        begin
            sg = obbcsp_pkg::corner_signs(3'(k));
            for (int i = 0; i < 3; i++)
                loc[i] = sg[i] ? e[i] : -e[i];
            for (int i = 0; i < 3; i++)
            begin
                acc = c[i] * 32768;
                for (int j = 0; j < 3; j++)
                    acc += r14[i][j] * loc[j];
                p[i] = rnd_shift(acc, 11);
            end
            for (int j = 0; j < 4; j++)
            begin
                acc = m[3][j] * 4096;
                for (int i = 0; i < 3; i++)
                    acc += p[i] * m[i][j];
                h[j] = clip(rnd_shift(acc, 12), -hlim, hlim);
            end
            sx = 0;
            sy = 0;
            if (h[3] > 0)
            begin
                sx = to_pixels(h[0] + h[3], h[3], wd);
                sy = to_pixels(h[3] - h[1], h[3], ht);
            end
            cw.idx  = 3'(k);
            cw.sx   = 16'(sx);
            cw.sy   = 16'(sy);
            cw.bad  = (h[3] <= 0);
            cw.last = (k == 7);
            corner_expected.push_back(cw);
        end
    endtask

    // Box driver: idles at random, holds the word until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_bus.valid <= 1'b0;
            {box_bus.centre_x, box_bus.centre_y, box_bus.centre_z, box_bus.extent_x,
             box_bus.extent_y, box_bus.extent_z, box_bus.quat_x, box_bus.quat_y,
             box_bus.quat_z, box_bus.quat_w} <= '0;
        end
        else
        begin
            if (box_bus.valid && box_bus.ready)
            begin
                predict_corners({box_bus.centre_x, box_bus.centre_y, box_bus.centre_z,
                                 box_bus.extent_x, box_bus.extent_y, box_bus.extent_z,
                                 box_bus.quat_x, box_bus.quat_y, box_bus.quat_z,
                                 box_bus.quat_w});
                boxes_sent++;
            end
            if (!box_bus.valid || box_bus.ready)
            begin
                if (box_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    box_word_t b;
                    b = box_queue.pop_front();
                    box_bus.valid <= 1'b1;
                    {box_bus.centre_x, box_bus.centre_y, box_bus.centre_z,
                     box_bus.extent_x, box_bus.extent_y, box_bus.extent_z,
                     box_bus.quat_x, box_bus.quat_y, box_bus.quat_z,
                     box_bus.quat_w} <= b;
                end
                else
                    box_bus.valid <= 1'b0;
            end
        end
    end

    // Corner monitor and sink-side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            corner_bus.ready <= 1'b0;
        else
        begin
            if (corner_bus.valid && corner_bus.ready)
            begin
                corner_word_t got, want;
                got = {corner_bus.corner_index, corner_bus.screen_x, corner_bus.screen_y,
                       corner_bus.w_invalid, corner_bus.last_corner};
                corners_seen++;
                if (corner_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected corner word %p", got);
                end
                else
                begin
                    want = corner_expected.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("corner mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            corner_bus.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Config write channel: one word per request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bus.valid <= 1'b0;
            cfg_bus.index <= '0;
            cfg_bus.data  <= '0;
        end
        else if (cfg_bus.valid)
        begin
            if (cfg_bus.ready)
            begin
                cfg_bus.valid <= 1'b0;
                cfg_done <= 1'b1;
            end
        end
        else if (cfg_req && !cfg_done)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= cfg_req_idx;
            cfg_bus.data  <= cfg_req_data;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input obbcsp_pkg::cfg_reg_t r, input logic [63:0] v);
        cfg_req_idx  = r;
        cfg_req_data = v;
        cfg_req = 1'b1;
        @(posedge clk);
        while (!cfg_done)
            @(posedge clk);
        cfg_req = 1'b0;
        @(posedge clk);
        cfg_done = 1'b0;
        if (r == obbcsp_pkg::REG_TARGET_RES)
            target_res = v[31:0];
        else
            mat_row[r] = v;
    endtask

    // Wait for every queued box to be taken and every corner to arrive
    task automatic drain();
        while (box_queue.size() > 0 || box_bus.valid || corner_expected.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_q();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(32768)) - 16384);
            1: return 16'($urandom);
            2: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic logic [15:0] rnd_coord();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(4096)) - 2048);
    endfunction

    function automatic box_word_t rnd_box();
        box_word_t b;
        b.cx = rnd_coord();
        b.cy = rnd_coord();
        b.cz = rnd_coord();
        b.ex = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
        b.ey = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
        b.ez = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
        b.qx = rnd_q();
        b.qy = rnd_q();
        b.qz = rnd_q();
        b.qw = rnd_q();
        return b;
    endfunction

    // Random matrix row, entries mostly small around +-1.0 in Q4.12
    function automatic logic [63:0] rnd_row();
        logic [63:0] r;
        for (int j = 0; j < 4; j++)
            r[16*j +: 16] = ($urandom_range(4) == 0) ? 16'($urandom)
                          : 16'($signed($urandom_range(8192)) - 4096);
        return r;
    endfunction

    initial
    begin
        box_word_t b;
        mat_row[0] = obbcsp_pkg::ROW_ZERO_RESET;
        mat_row[1] = obbcsp_pkg::ROW_ONE_RESET;
        mat_row[2] = obbcsp_pkg::ROW_TWO_RESET;
        mat_row[3] = obbcsp_pkg::ROW_THREE_RESET;
        target_res = obbcsp_pkg::RES_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, identity quaternion, extremes
        box_queue.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100,
                              16'h0000, 16'h0000, 16'h0000, 16'h4000});
        box_queue.push_back('{16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'h4000, 16'h0000, 16'h0000, 16'h0000});
        box_queue.push_back('{16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                              16'hC000, 16'hC000, 16'hC000, 16'hC000});
        box_queue.push_back('{16'h0080, 16'hFF80, 16'h0000, 16'h0040, 16'h0080, 16'h00C0,
                              16'h2D41, 16'h0000, 16'h2D41, 16'h0000});
        box_queue.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF,
                              16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001});
        drain();
        // Perspective-like matrix with w from z: some corners behind camera
        write_reg(obbcsp_pkg::REG_ROW_TWO, 64'h1000_0000_0000_0000);
        write_reg(obbcsp_pkg::REG_ROW_THREE, 64'h0000_0000_0000_0000);
        write_reg(obbcsp_pkg::REG_TARGET_RES, 32'h0000_0000);
        box_queue.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0200, 16'h0200, 16'h0200,
                              16'h0000, 16'h0000, 16'h0000, 16'h4000});
        box_queue.push_back('{16'h0010, 16'h0010, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 16'h0000, 16'h4000});
        drain();
        write_reg(obbcsp_pkg::REG_TARGET_RES, 32'hFFFF_FFFF);
        write_reg(obbcsp_pkg::REG_ROW_ZERO, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(obbcsp_pkg::REG_ROW_ONE, 64'h8000_8000_8000_8000);
        write_reg(obbcsp_pkg::REG_ROW_THREE, 64'h1000_8000_7FFF_1000);
        for (int i = 0; i < 6; i++)
            box_queue.push_back(rnd_box());
        drain();

        // Random phases with varied settings; one phase with no idling
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(obbcsp_pkg::REG_ROW_ZERO, rnd_row());
            write_reg(obbcsp_pkg::REG_ROW_ONE, rnd_row());
            write_reg(obbcsp_pkg::REG_ROW_TWO, rnd_row());
            write_reg(obbcsp_pkg::REG_ROW_THREE,
                      {16'h1000 + 16'($urandom_range(16383)), 48'($urandom)});
            write_reg(obbcsp_pkg::REG_TARGET_RES, (ph == 5) ? 32'($urandom)
                      : {16'($urandom_range(2048)), 16'($urandom_range(4096))});
            idle_pct = (ph == 3) ? 0 : 14;
            for (int i = 0; i < 48; i++)
                box_queue.push_back(rnd_box());
            drain();
        end
        idle_pct = 14;
        repeat (LAT) @(posedge clk);

        $display("sent %0d boxes, checked %0d corner words over several matrix and",
                 boxes_sent, corners_seen);
        $display("resolution settings, including extremes and non-positive w");
        if (mismatches == 0 && corner_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== files.f =====
sv/obbcsp_pkg.sv
sv/obbcsp_cfg_if.sv
sv/obbcsp_box_if.sv
sv/obbcsp_corner_if.sv
sv/obbcsp_div.sv
sv/obb_corner_screen_projection.sv
tb/sv/tb_top.sv
